// File: rtl/pcsr_pkg.sv
// ----------------------------------------------------------------------------
// pcsr_pkg: shared types and constants of the column-span rasterizer
// Register indexes, sequencer states, and the fixed coordinate limits.
// ----------------------------------------------------------------------------
package pcsr_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned MaxSpans  = 64;
  localparam int unsigned SpanBits  = $clog2(MaxSpans);
  localparam int unsigned ColBits   = CoordBits + 1;

  typedef enum logic [2:0] {
    REG_X_SCALE      = 3'd0,
    REG_X_PER_COLUMN = 3'd1,
    REG_Y_SCALE      = 3'd2,
    REG_Y_OFFSET     = 3'd3,
    REG_PLOT_HEIGHT  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW0,
    ST_DIV,
    ST_WALK,
    ST_MUL,
    ST_ROW,
    ST_EMIT,
    ST_JOIN,
    ST_JOINEMIT,
    ST_DONE
  } state_e;

  // Request to and answer from the shared row mapper.
  typedef struct packed {
    logic               start;
    logic signed [32:0] y;
  } row_req_t;

  typedef struct packed {
    logic                 done;
    logic [CoordBits-1:0] row;
  } row_rsp_t;

endpackage

// File: rtl/pcsr_row_map.sv
// ----------------------------------------------------------------------------
// pcsr_row_map: maps a Q16.16 value to a saturated pixel row
// Registers the product by y_scale, then rounds and saturates it.
// ----------------------------------------------------------------------------
module pcsr_row_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcsr_pkg::row_req_t req_i,
  input  logic [31:0]       y_scale_i,
  input  logic [31:0]       y_offset_i,
  input  logic [12:0]       plot_height_i,
  output pcsr_pkg::row_rsp_t rsp_o
);
  import pcsr_pkg::*;

  logic signed [33:0] diff;
  logic               neg_q;
  logic [64:0]        prod_q;
  logic               busy_q;
  logic [33:0]        rnd;
  logic [12:0]        lim;
  logic [12:0]        limit;

  assign diff = 34'(req_i.y) - 34'($signed(y_offset_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q  <= diff[33];
      prod_q <= 65'(diff[32:0]) * 65'(y_scale_i);
    end
  end

  always_comb begin
    lim   = (plot_height_i < 13'(1 << CoordBits)) ? plot_height_i : 13'(1 << CoordBits);
    limit = (lim != '0) ? lim - 13'd1 : '0;
    rnd   = 34'((prod_q + 65'h8000_0000) >> 32);
    rsp_o.done = busy_q;
    if (neg_q) begin
      rsp_o.row = '0;
    end else if (rnd > 34'(limit)) begin
      rsp_o.row = limit[CoordBits-1:0];
    end else begin
      rsp_o.row = rnd[CoordBits-1:0];
    end
  end

endmodule

// File: rtl/polyline_column_span_rasterizer_core.sv
// ----------------------------------------------------------------------------
// polyline_column_span_rasterizer_core: polyline to vertical column spans
// Walks the columns of each segment and emits one row span per walked column,
// plus a join span to the endpoint row where needed.
// A point that starts a curve gives no spans. A continuing point first
// computes the slope with a restoring divider that retires one quotient bit
// a cycle, followed by a finishing step. The row mapper resolves the
// endpoint row in the same window. Each walked column then goes through
// column setup, interpolation multiply, row mapping and emission; the first
// column skips the multiply. The endpoint check, a join span where needed
// and the wrap-up follow. Emission and wrap-up wait while an earlier span is
// held by a stalled output. The slope divider, one 32x32 multiplier and the
// row mapper each exist once and are reused for every point. in_ready_o is
// high only while the sequencer is idle and no register write is offered.
// cfg_ready_o is high only while the sequencer is idle.
module polyline_column_span_rasterizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] sample_x_i,
  input  logic [31:0] sample_y_i,
  input  logic [7:0]  curve_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] column_o,
  output logic [11:0] row_low_o,
  output logic [11:0] row_high_o,
  output logic [7:0]  color_o,
  output logic        overflow_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import pcsr_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [21:0] x_scale_q;
  logic [31:0] x_per_col_q, y_scale_q, y_offset_q;
  logic [12:0] plot_height_q;

  // curve state
  logic [15:0]        prev_x_q;
  logic signed [31:0] prev_y_q;
  logic [ColBits-1:0] next_col_q;
  logic [CoordBits-1:0] prev_row_q;
  logic signed [31:0] slope_q;
  logic               open_q;
  logic [7:0]         color_q;

  // item in flight
  logic [15:0]        x_q;
  logic signed [31:0] y_q;
  logic [37:0]        px2_q;
  logic [ColBits-1:0] col_q;
  logic [SpanBits-1:0] n_q;
  logic               first_q, ov_q;
  logic [CoordBits-1:0] row_q;
  logic [CoordBits-1:0] pe_q;

  // divider
  logic [32:0] rem_q, quo_q;
  logic [16:0] dvs_q;
  logic [5:0]  dcnt_q;
  logic        qneg_q;

  // shared multiplier operands and result
  logic [31:0]        t_sat_q;
  logic               t_pos_q;
  logic signed [31:0] yi_q;

  // output register
  logic        ovalid_q;
  logic [11:0] o_col_q, o_lo_q, o_hi_q;
  logic        o_last_q;

  row_req_t rreq;
  row_rsp_t rrsp;

  pcsr_row_map u_row (
    .clk_i, .rst_ni, .req_i(rreq), .y_scale_i(y_scale_q), .y_offset_i(y_offset_q),
    .plot_height_i(plot_height_q), .rsp_o(rrsp)
  );

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_valid_o = ovalid_q;
  assign column_o    = o_col_q;
  assign row_low_o   = o_lo_q;
  assign row_high_o  = o_hi_q;
  assign color_o     = color_q;
  assign overflow_o  = ov_q;
  assign last_o      = o_last_q;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // walk condition: column still inside the segment and the plot
  logic walk_ok;
  assign walk_ok = ({9'd0, col_q, 16'h0} <= px2_q) && (col_q < ColBits'(1 << CoordBits));

  // the column after this one is walked too
  logic [ColBits-1:0] col_nx;
  logic               walk_next;
  assign col_nx    = col_q + 1'b1;
  assign walk_next = ({9'd0, col_nx, 16'h0} <= px2_q) && (col_nx < ColBits'(1 << CoordBits));

  // endpoint row needs a join after a span ending at row_q
  logic join_pe;
  assign join_pe = ({1'b0, pe_q} > {1'b0, row_q} + 13'd1) ||
                   ({1'b0, row_q} > {1'b0, pe_q} + 13'd1);

  // this walk span closes the point's output
  logic emit_last;
  assign emit_last = !(walk_next && n_q != SpanBits'(MaxSpans - 2)) && !join_pe;

  // segment skips columns past the span limit
  logic [ColBits:0] lim_col;
  logic             ov_pred;
  assign lim_col = {1'b0, next_col_q} + 14'(MaxSpans - 1);
  assign ov_pred = ({8'd0, lim_col, 16'h0} <= px2_new) &&
                   (lim_col < 14'(1 << CoordBits));

  // interpolation: t = j*x_per_column - prev_x<<16, saturated
  logic [44:0] jx;
  logic signed [46:0] t_full;
  logic [31:0] t_sat;
  logic        t_pos;
  logic [31:0] smag;
  logic [63:0] prod;
  logic signed [48:0] delta;
  logic signed [49:0] ysum;
  always_comb begin
    jx     = 45'(col_q) * 45'(x_per_col_q);
    t_full = $signed({2'b00, jx}) - $signed({15'd0, prev_x_q, 16'h0});
    t_pos  = (t_full > 0);
    t_sat  = (t_full > 47'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : t_full[31:0];
    smag   = slope_q[31] ? 32'(-slope_q) : slope_q;
    prod   = 64'(smag) * 64'(t_sat_q);
    delta  = slope_q[31] ? -$signed({1'b0, 48'((prod + 64'hFFFF) >> 16)})
                         : $signed({1'b0, prod[63:16]});
    ysum   = 50'(prev_y_q) + 50'(delta);
  end

  // span bounds against the previous row
  logic [CoordBits-1:0] sp_lo, sp_hi;
  always_comb begin
    sp_lo = row_q;
    sp_hi = row_q;
    if ({1'b0, prev_row_q} > {1'b0, row_q} + 13'd1) begin
      sp_hi = prev_row_q - 1'b1;
    end else if ({1'b0, row_q} > {1'b0, prev_row_q} + 13'd1) begin
      sp_lo = prev_row_q + 1'b1;
    end
  end

  logic join_need;
  assign join_need = ({1'b0, rrsp.row} > {1'b0, prev_row_q} + 13'd1) ||
                     ({1'b0, prev_row_q} > {1'b0, rrsp.row} + 13'd1);

  logic [37:0] px2_new;
  logic [37:0] c_new;
  assign px2_new = 38'(x_scale_q) * 38'(sample_x_i);
  assign c_new   = (px2_new + 38'h8000) >> 16;

  // sequencer
  always_comb begin
    state_d   = state_q;
    rreq.start = 1'b0;
    rreq.y     = 33'(y_q);
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (!action_i || !open_q) ? ST_ROW0 : ST_DIV;
        end
      end
      ST_ROW0: begin
        rreq.start = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DIV: begin
        // map the endpoint row while the divider runs
        if (dcnt_q == 6'd33) rreq.start = 1'b1;
        if (dcnt_q == '0) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_ok && n_q != SpanBits'(MaxSpans - 1)) begin
          state_d = first_q ? ST_ROW : ST_MUL;
        end else begin
          state_d = ST_JOIN;
        end
      end
      ST_MUL: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        if (!rrsp.done) begin
          rreq.start = 1'b1;
          rreq.y     = 33'(yi_q);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q) state_d = ST_WALK;
      end
      ST_JOIN: begin
        if (!rrsp.done) begin
          rreq.start = 1'b1;
        end else begin
          state_d = join_need ? ST_JOINEMIT : ST_DONE;
        end
      end
      ST_JOINEMIT: begin
        if (!ovalid_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q     <= 22'd65536;
      x_per_col_q   <= 32'd65536;
      y_scale_q     <= 32'd65536;
      y_offset_q    <= '0;
      plot_height_q <= 13'd480;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_X_SCALE:      x_scale_q     <= cfg_data_i[21:0];
        REG_X_PER_COLUMN: x_per_col_q   <= cfg_data_i;
        REG_Y_SCALE:      y_scale_q     <= cfg_data_i;
        REG_Y_OFFSET:     y_offset_q    <= cfg_data_i;
        REG_PLOT_HEIGHT:  plot_height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic [32:0] rem_sh;
  assign rem_sh = {rem_q[31:0], quo_q[32]};

  // datapath and curve state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      next_col_q <= '0;
      prev_row_q <= '0;
      slope_q    <= '0;
      open_q     <= 1'b0;
      color_q    <= '0;
      ovalid_q   <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            x_q     <= sample_x_i;
            y_q     <= sample_y_i;
            px2_q   <= px2_new;
            n_q     <= '0;
            first_q <= 1'b1;
            ov_q    <= (!action_i || !open_q) ? 1'b0 : ov_pred;
            col_q   <= next_col_q;
            dcnt_q  <= 6'd33;
            if (!action_i || !open_q) begin
              next_col_q <= (c_new > 38'(1 << CoordBits)) ? ColBits'(1 << CoordBits)
                                                          : c_new[ColBits-1:0];
              color_q  <= curve_color_i;
              open_q   <= 1'b1;
              prev_x_q <= sample_x_i;
              prev_y_q <= sample_y_i;
              slope_q  <= '0;
            end else begin
              // set up |dy| / |dx| restoring division
              logic signed [32:0] dy;
              logic signed [16:0] dx;
              dy = 33'(signed'(sample_y_i)) - 33'(prev_y_q);
              dx = 17'({1'b0, sample_x_i}) - 17'({1'b0, prev_x_q});
              quo_q  <= dy[32] ? 33'(-dy) : 33'(dy);
              dvs_q  <= dx[16] ? 17'(-dx) : 17'(dx);
              rem_q  <= '0;
              qneg_q <= dy[32] ^ dx[16];
            end
          end
        end
        ST_ROW0: ;
        ST_DIV: begin
          if (rrsp.done) pe_q <= rrsp.row;
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 1'b1;
            if (rem_sh >= 33'(dvs_q)) begin
              rem_q <= rem_sh - 33'(dvs_q);
              quo_q <= {quo_q[31:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[31:0], 1'b0};
            end
          end else if (dvs_q == '0) begin
            slope_q <= '0;
          end else if (qneg_q) begin
            slope_q <= (quo_q > 33'h8000_0000) ? 32'sh8000_0000 : 32'(-quo_q);
          end else begin
            slope_q <= (quo_q > 33'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_q[31:0];
          end
        end
        ST_WALK: begin
          if (walk_ok && n_q == SpanBits'(MaxSpans - 1)) begin
            ov_q  <= 1'b1;
            col_q <= (px2_q[37:16] > 22'((1 << CoordBits) - 1))
                     ? ColBits'(1 << CoordBits) : ColBits'(px2_q[37:16]) + 1'b1;
          end
          if (walk_ok && first_q) yi_q <= prev_y_q;
          // hold the interpolation offset for the multiply
          t_sat_q <= t_sat;
          t_pos_q <= t_pos;
        end
        ST_MUL: begin
          if (!t_pos_q) yi_q <= prev_y_q;
          else if (ysum > 50'sh7FFF_FFFF) yi_q <= 32'sh7FFF_FFFF;
          else if (ysum < -50'sh8000_0000) yi_q <= 32'sh8000_0000;
          else yi_q <= ysum[31:0];
        end
        ST_ROW: begin
          if (rrsp.done) row_q <= rrsp.row;
        end
        ST_EMIT: begin
          if (!ovalid_q) begin
            ovalid_q   <= 1'b1;
            o_col_q    <= col_q[11:0];
            o_lo_q     <= 12'(sp_lo);
            o_hi_q     <= 12'(sp_hi);
            o_last_q   <= emit_last;
            prev_row_q <= row_q;
            n_q        <= n_q + 1'b1;
            first_q    <= 1'b0;
            col_q      <= col_q + 1'b1;
          end
        end
        ST_JOIN: begin
          if (rrsp.done) begin
            row_q      <= rrsp.row;
            next_col_q <= col_q;
            prev_x_q   <= x_q;
            prev_y_q   <= y_q;
          end
        end
        ST_JOINEMIT: begin
          if (!ovalid_q) begin
            ovalid_q   <= 1'b1;
            o_col_q    <= (col_q != '0) ? 12'(col_q - 1'b1) : '0;
            o_lo_q     <= 12'(sp_lo);
            o_hi_q     <= 12'(sp_hi);
            o_last_q   <= 1'b1;
            prev_row_q <= row_q;
          end
        end
        ST_DONE: begin
          if (rrsp.done) prev_row_q <= rrsp.row;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/pcsr_checker.sv
// ----------------------------------------------------------------------------
// pcsr_checker: port-level checks of the rasterizer
// Watches the handshakes and the span fields at the top-level ports.
// ----------------------------------------------------------------------------
module pcsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        in_valid_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] row_low_o,
  input logic [11:0] row_high_o,
  input logic [11:0] column_o
);
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_low_o <= row_high_o) else $error("span rows out of order");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(column_o))
    else $error("span dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready while busy");

endmodule

bind polyline_column_span_rasterizer_core pcsr_checker u_pcsr_checker (
  .clk_i, .rst_ni, .in_ready_o, .in_valid_i, .out_valid_o, .out_ready_i,
  .row_low_o, .row_high_o, .column_o
);

// File: tb/pcsr_tb_pkg.sv
// ----------------------------------------------------------------------------
// pcsr_tb_pkg: testbench-side codes for the column-span rasterizer
// Point actions and the span record shared by stimulus and checker.
// ----------------------------------------------------------------------------
package pcsr_tb_pkg;

  typedef enum logic {
    ACT_START    = 1'b0,
    ACT_CONTINUE = 1'b1
  } point_act_e;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row_low;
    logic [11:0] row_high;
    logic [7:0]  color;
    logic        overflow;
    logic        last;
  } span_t;

endpackage

// File: tb/pcsr_span_checker.sv
// ----------------------------------------------------------------------------
// pcsr_span_checker: span predictor and scoreboard
// Tracks register writes and points, predicts spans, checks each output.
// ----------------------------------------------------------------------------
module pcsr_span_checker
  import pcsr_pkg::*;
  import pcsr_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [15:0] sample_x_i,
  input  logic [31:0] sample_y_i,
  input  logic [7:0]  curve_color_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [11:0] column_i,
  input  logic [11:0] row_low_i,
  input  logic [11:0] row_high_i,
  input  logic [7:0]  color_i,
  input  logic        overflow_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_o,
  output int          pending_o
);

  localparam longint unsigned ColLimit = longint'(1) << CoordBits;

  logic [21:0]     x_scale;
  logic [31:0]     x_per_col;
  logic [31:0]     y_scale;
  longint          y_offset;
  logic [12:0]     plot_height;

  int unsigned     prev_x;
  longint          prev_y;
  longint unsigned next_col;
  int unsigned     prev_row;
  longint          slope;
  bit              curve_open;
  logic [7:0]      cur_color;

  span_t           spans_q[$];
  span_t           point_spans[$];
  int              fails;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact row of y, rounded half up, clamped to the plot.
  function automatic int unsigned row_for(longint yv);
    longint      diff;
    logic [65:0] acc;
    int unsigned lim;
    lim = (plot_height < ColLimit) ? plot_height : ColLimit;
    lim = (lim != 0) ? lim - 1 : 0;
    diff = yv - y_offset;
    if (diff < 0) return 0;
    acc = 66'(diff) * 66'(y_scale) + 66'h8000_0000;
    acc = acc >> 32;
    if (acc > lim) return lim;
    return int'(acc);
  endfunction

  function automatic longint interp_y(int unsigned j);
    longint          t;
    longint unsigned mag, prod;
    longint          delta;
    t = longint'(j) * longint'({32'd0, x_per_col}) - (longint'(prev_x) << 16);
    if (t <= 0) return prev_y;
    if (t > 64'sh0_FFFF_FFFF) t = 64'sh0_FFFF_FFFF;
    mag = (slope < 0) ? longint'(-slope) : longint'(slope);
    prod = mag * longint'(t);
    if (slope < 0) delta = -longint'((prod + 64'hFFFF) >> 16);
    else delta = longint'(prod >> 16);
    return sat32(prev_y + delta);
  endfunction

  function automatic void add_span(int unsigned col, int unsigned q);
    span_t s;
    s = '0;
    s.column = col[11:0];
    s.row_low = q[11:0];
    s.row_high = q[11:0];
    if (prev_row > q + 1) s.row_high = 12'(prev_row - 1);
    else if (q > prev_row + 1) s.row_low = 12'(prev_row + 1);
    point_spans.push_back(s);
    prev_row = q;
  endfunction

  task automatic predict_point(logic act, logic [15:0] x, logic [31:0] yraw,
                               logic [7:0] colr);
    longint          yv, dx, yi;
    longint unsigned px2, e;
    int unsigned     j, pe;
    bit              ov, first;
    span_t           s;
    yv = longint'($signed(yraw));
    px2 = longint'({42'd0, x_scale}) * longint'({48'd0, x});
    point_spans.delete();
    if (act == ACT_START || !curve_open) begin
      // open a curve: record the point, nothing is drawn
      e = (px2 + 64'h8000) >> 16;
      next_col = (e > ColLimit) ? ColLimit : e;
      prev_row = row_for(yv);
      cur_color = colr;
      curve_open = 1'b1;
      prev_x = x;
      prev_y = yv;
      slope = 0;
      return;
    end
    dx = longint'(x) - longint'(prev_x);
    slope = (dx != 0) ? sat32((yv - prev_y) / dx) : 0;
    j = int'(next_col);
    first = 1'b1;
    ov = 1'b0;
    while ((longint'(j) << 16) <= px2 && j < ColLimit) begin
      if (point_spans.size() >= MaxSpans - 1) begin
        // span limit hit: skip the rest of the segment's columns
        e = px2 >> 16;
        if (e > ColLimit - 1) e = ColLimit - 1;
        j = int'(e) + 1;
        ov = 1'b1;
        break;
      end
      yi = first ? prev_y : interp_y(j);
      first = 1'b0;
      add_span(j, row_for(yi));
      j++;
    end
    next_col = j;
    pe = row_for(yv);
    if (pe > prev_row + 1 || prev_row > pe + 1) add_span((j != 0) ? j - 1 : 0, pe);
    foreach (point_spans[k]) begin
      s = point_spans[k];
      s.color = cur_color;
      s.overflow = ov;
      s.last = (k == point_spans.size() - 1);
      spans_q.push_back(s);
    end
    prev_x = x;
    prev_y = yv;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    span_t got, want;
    if (!rst_ni) begin
      x_scale = 22'd65536;
      x_per_col = 32'd65536;
      y_scale = 32'd65536;
      y_offset = 0;
      plot_height = 13'd480;
      prev_x = 0;
      prev_y = 0;
      next_col = 0;
      prev_row = 0;
      slope = 0;
      curve_open = 1'b0;
      cur_color = '0;
      spans_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {column_i, row_low_i, row_high_i, color_i, overflow_i, last_i};
        if (spans_q.size() == 0) begin
          $display("%0t unexpected span: expected none actual %p", $time, got);
          fails++;
        end else begin
          want = spans_q.pop_front();
          if (got !== want) begin
            $display("%0t span mismatch: expected %p actual %p", $time, want, got);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_X_SCALE:      x_scale = cfg_data_i[21:0];
          REG_X_PER_COLUMN: x_per_col = cfg_data_i;
          REG_Y_SCALE:      y_scale = cfg_data_i;
          REG_Y_OFFSET:     y_offset = longint'($signed(cfg_data_i));
          REG_PLOT_HEIGHT:  plot_height = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_point(action_i, sample_x_i, sample_y_i, curve_color_i);
    end
    fail_o <= fails;
    pending_o <= spans_q.size();
  end

endmodule

// File: tb/polyline_column_span_rasterizer_core_test.sv
// ----------------------------------------------------------------------------
// polyline_column_span_rasterizer_core_test: stimulus and verdict
// Drives curves of points and register settings into the rasterizer with
// random idling on both channels; a checker beside the block predicts and
// compares every span.
// ----------------------------------------------------------------------------
module polyline_column_span_rasterizer_core_test;
  import pcsr_pkg::*;
  import pcsr_tb_pkg::*;

  localparam int RandomPoints = 420;
  localparam int PhaseCount   = 6;
  localparam int StallLimit   = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        action_i;
  logic [15:0] sample_x_i;
  logic [31:0] sample_y_i;
  logic [7:0]  curve_color_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [11:0] column_o;
  logic [11:0] row_low_o;
  logic [11:0] row_high_o;
  logic [7:0]  color_o;
  logic        overflow_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int fail_count;
  int spans_pending;
  int idle_cycles;

  // Stimulus controls shared with the receiver process.
  bit calm;
  bit long_hold_req;

  logic [15:0] cur_x;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polyline_column_span_rasterizer_core u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .action_i, .sample_x_i, .sample_y_i, .curve_color_i,
    .out_valid_o, .out_ready_i,
    .column_o, .row_low_o, .row_high_o, .color_o, .overflow_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pcsr_span_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .action_i, .sample_x_i, .sample_y_i, .curve_color_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .column_i(column_o), .row_low_i(row_low_o), .row_high_i(row_high_o),
    .color_i(color_o), .overflow_i(overflow_o), .last_i(last_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_o(fail_count), .pending_o(spans_pending)
  );

  // Watchdog: count cycles in which no transfer happens on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random back-pressure bursts, one long hold-off on request,
  // and a steady ready once the run goes calm.
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        // hold off long enough that the block stalls its input
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Offer one point and hold it until the transfer; valid stays high after.
  task automatic send_point(point_act_e act, logic [15:0] x, logic [31:0] y,
                            logic [7:0] colr);
    in_valid_i <= 1'b1;
    action_i <= act;
    sample_x_i <= x;
    sample_y_i <= y;
    curve_color_i <= colr;
    do @(posedge clk_i); while (!in_ready_o);
    cur_x = x;
  endtask

  // Drop valid for a random burst now and then.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Wait until the block is idle and every span has arrived, then let a
  // point that draws nothing finish its slope pass.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (spans_pending != 0 || !in_ready_o);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(logic [31:0] xs, logic [31:0] xpc, logic [31:0] ys,
                               logic [31:0] yo, logic [31:0] ph);
    drain();
    write_reg(REG_X_SCALE, xs);
    write_reg(REG_X_PER_COLUMN, xpc);
    write_reg(REG_Y_SCALE, ys);
    write_reg(REG_Y_OFFSET, yo);
    write_reg(REG_PLOT_HEIGHT, ph);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_y();
    // mostly a band around zero, sometimes anything
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 600 << 16)) - 32'(300 << 16);
  endfunction

  function automatic logic [7:0] pick_color();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin
    int sent, per_phase, run_len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    sample_x_i = '0;
    sample_y_i = '0;
    curve_color_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_X_SCALE;
    cfg_data_i = '0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    cur_x = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset settings.
    send_point(ACT_CONTINUE, 16'd5, 32'h0005_0000, 8'd1);   // continue, no curve open
    send_point(ACT_CONTINUE, 16'd9, 32'h7FFF_FFFF, 8'd2);   // steep rise, saturated row
    send_point(ACT_CONTINUE, 16'd9, 32'h8000_0000, 8'd3);   // equal x, drop to row zero
    send_point(ACT_CONTINUE, 16'd9, 32'h8000_0000, 8'd3);   // nothing to draw
    send_point(ACT_CONTINUE, 16'd200, 32'h0064_0000, 8'd4); // long segment, span limit
    send_point(ACT_CONTINUE, 16'hFFFF, 32'h0000_0000, 8'd5); // walk to the column limit
    send_point(ACT_START, 16'd0, 32'hFFFF_FFFF, 8'd255);
    send_point(ACT_CONTINUE, 16'd0, 32'h0000_0000, 8'd0);
    send_point(ACT_CONTINUE, 16'd1, 32'h01E0_0000, 8'd7);
    send_point(ACT_CONTINUE, 16'd3, 32'h0000_8000, 8'd7);
    send_point(ACT_CONTINUE, 16'd2, 32'h0010_0000, 8'd7);   // x steps back
    send_point(ACT_START, 16'hFFFF, 32'h7FFF_FFFF, 8'hAA);
    send_point(ACT_CONTINUE, 16'h0000, 32'h8000_0000, 8'h55);

    // Zero plot height with the widest column scale.
    load_settings(32'd4063232, 32'd1057, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
    send_point(ACT_START, 16'd0, 32'h0000_0000, 8'd9);
    send_point(ACT_CONTINUE, 16'd1, 32'h0100_0000, 8'd9);
    send_point(ACT_CONTINUE, 16'd3, 32'hFF00_0000, 8'd9);

    // Random curves, one register setting per phase.
    sent = 0;
    per_phase = RandomPoints / PhaseCount;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: load_settings(32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd480);
        1: load_settings(32'd4063232, 32'd1057, 32'h0008_0000, 32'hFF9C_0000, 32'd4096);
        2: load_settings(32'd32768, 32'd131072, 32'h0004_0000, 32'd0, 32'd1);
        3: load_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd8191);
        4: load_settings(32'($urandom_range(0, 4063232)), $urandom, $urandom, $urandom,
                         32'($urandom_range(0, 8191)));
        default: load_settings(32'd131072, 32'd32768, 32'h0003_0000, 32'hFFF0_0000, 32'd480);
      endcase
      calm = (phase == PhaseCount - 1);
      while (sent < per_phase * (phase + 1)) begin
        // a curve, mostly well-formed: a start, then points mostly moving right
        maybe_gap();
        if ($urandom_range(0, 9) == 0) begin
          send_point(point_act_e'($urandom_range(0, 1)), 16'($urandom), $urandom,
                     pick_color());
        end else begin
          send_point(ACT_START, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                     : 16'($urandom_range(0, 60)), pick_y(), pick_color());
        end
        sent++;
        run_len = $urandom_range(1, 12);
        for (int k = 0; k < run_len; k++) begin
          maybe_gap();
          if ($urandom_range(0, 7) == 0)
            send_point(ACT_CONTINUE, 16'($urandom), pick_y(), pick_color());
          else
            send_point(ACT_CONTINUE, cur_x + 16'($urandom_range(0, 5)), pick_y(),
                       pick_color());
          sent++;
        end
        if (phase == 2 && !long_hold_req && sent > per_phase * 2 + 20)
          long_hold_req = 1'b1;
        if (phase == 3 && sent > per_phase * 3 + 30 && sent < per_phase * 3 + 45) begin
          // pause the sender until every span is out
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (spans_pending != 0);
        end
      end
    end

    // Let the last spans drain, then give the verdict.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (spans_pending != 0 || !in_ready_o);
    repeat (500) @(posedge clk_i);
    if (fail_count == 0 && spans_pending == 0) begin
      $display("CHECK OK");
    end else begin
      if (spans_pending != 0)
        $display("%0t spans missing: expected %0d more actual 0", $time, spans_pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
